// File: rtl/core/psrm_pkg.sv
// Package: widths, codes and cell control types for the positional range-min core.
package psrm_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = 11;
  localparam int unsigned REND_W   = 10;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic signed [VAL_W-1:0] EMPTY_RANGE_MIN = 32'sd1000000100;
  localparam logic signed [VAL_W-1:0] MIN_SEED        = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_MIN    = 2'd1,
    MODE_ERASE  = 2'd2,
    MODE_WRITE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ERASE,
    CELL_WRITE,
    CELL_SCAN
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    cell_op_e                op;
    logic [CMP_W-1:0]        pos;
    logic [CMP_W-1:0]        lo;
    logic [CMP_W-1:0]        hi;
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

// File: rtl/core/psrm_cell.sv
// One storage cell: holds an entry, shifts with its neighbors and folds the running minimum.
module psrm_cell
  import psrm_pkg::*;
(
  input  logic                    clk_i,
  input  logic [CMP_W-1:0]        idx_i,
  input  cell_ctl_t               ctl_i,
  input  logic signed [VAL_W-1:0] prev_val_i,
  input  logic signed [VAL_W-1:0] next_val_i,
  input  logic signed [VAL_W-1:0] acc_i,
  output logic signed [VAL_W-1:0] val_o,
  output logic signed [VAL_W-1:0] acc_o
);

  logic signed [VAL_W-1:0] val_q, val_d;
  logic signed [VAL_W-1:0] acc_q, acc_d;
  logic                    in_range;

  assign in_range = (idx_i >= ctl_i.lo) && (idx_i <= ctl_i.hi);

  always_comb begin
    val_d = val_q;
    case (ctl_i.op)
      CELL_INSERT: begin
        if (idx_i == ctl_i.pos) begin
          val_d = ctl_i.value;
        end else if (idx_i > ctl_i.pos) begin
          val_d = prev_val_i;
        end
      end
      CELL_ERASE: begin
        if (idx_i >= ctl_i.pos) begin
          val_d = next_val_i;
        end
      end
      CELL_WRITE: begin
        if (idx_i == ctl_i.pos) begin
          val_d = ctl_i.value;
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_comb begin
    acc_d = acc_i;
    if (in_range && (val_q < acc_i)) begin
      acc_d = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    acc_q <= acc_d;
  end

  assign val_o = val_q;
  assign acc_o = acc_q;

endmodule

// File: rtl/core/positional_sequence_range_min_core.sv
// Top level: ordered sequence store with insert, erase, write and range minimum.
//
// Insert, erase and write: all cells shift or load in the accept cycle and the result
// word is registered in S_DONE once the output register is free. A range minimum over a
// nonempty range passes through S_SCAN: the running minimum travels down the row of cells
// one cell per cycle and is read at the last cell. An empty or reversed range skips S_SCAN.
// A new word is accepted while the previous result still waits on the master side.
// s_axis_tdata: position [10:0], range_end [20:11], value [52:21], zero fill [55:53].
// s_axis_tuser: mode [1:0]. m_axis_tdata: minimum [31:0], status [33:32], length [44:34].
module positional_sequence_range_min_core
  import psrm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // position, range_end, value
  input  logic [1:0]            s_axis_tuser,  // mode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // minimum, status, length
);

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [IDX_W-1:0]        scan_cnt_q, scan_cnt_d;
  logic [CMP_W-1:0]        lo_q, lo_d, hi_q, hi_d;
  logic signed [VAL_W-1:0] res_min_q, res_min_d;
  status_e                 res_st_q, res_st_d;
  logic                    scan_q, scan_d;
  logic                    out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0]   out_data_q, out_data_d;

  logic                    accept, out_free, full, empty;
  mode_e                   mode;
  logic [POS_W-1:0]        in_pos;
  logic [REND_W-1:0]       in_rend;
  logic signed [VAL_W-1:0] in_val;
  logic [CMP_W-1:0]        pos_w, rend_w, cnt_w, hi_c;
  logic [CMP_W-1:0]        len_w;
  logic signed [VAL_W-1:0] min_out;
  cell_ctl_t               ctl;

  logic signed [VAL_W-1:0] vals [CAPACITY];
  logic signed [VAL_W-1:0] accs [CAPACITY];

  assign mode    = mode_e'(s_axis_tuser);
  assign in_pos  = s_axis_tdata[10:0];
  assign in_rend = s_axis_tdata[20:11];
  assign in_val  = s_axis_tdata[52:21];

  assign pos_w  = CMP_W'(in_pos);
  assign rend_w = CMP_W'(in_rend);
  assign cnt_w  = CMP_W'(count_q);
  assign hi_c   = (rend_w >= cnt_w) ? (cnt_w - CMP_W'(1)) : rend_w;
  assign empty  = (cnt_w == '0) || (pos_w >= cnt_w) || (pos_w > hi_c);
  assign full   = (cnt_w >= CMP_W'(CAPACITY));

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [VAL_W-1:0] prev_v, next_v, acc_in;
      if (gi == 0) begin : g_first
        assign prev_v = ctl.value;
        assign acc_in = MIN_SEED;
      end else begin : g_mid
        assign prev_v = vals[gi-1];
        assign acc_in = accs[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign next_v = vals[gi];
      end else begin : g_inner
        assign next_v = vals[gi+1];
      end
      psrm_cell u_cell (
        .clk_i      (clk_i),
        .idx_i      (CMP_W'(gi)),
        .ctl_i      (ctl),
        .prev_val_i (prev_v),
        .next_val_i (next_v),
        .acc_i      (acc_in),
        .val_o      (vals[gi]),
        .acc_o      (accs[gi])
      );
    end
  endgenerate

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (mode == MODE_MIN && !empty) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_cnt_q == IDX_W'(CAPACITY - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.op      = CELL_HOLD;
    ctl.pos     = pos_w;
    ctl.lo      = lo_q;
    ctl.hi      = hi_q;
    ctl.value   = in_val;
    count_d     = count_q;
    scan_cnt_d  = '0;
    lo_d        = lo_q;
    hi_d        = hi_q;
    res_min_d   = res_min_q;
    res_st_d    = res_st_q;
    scan_d      = scan_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_min_d = '0;
          res_st_d  = ST_OK;
          scan_d    = 1'b0;
          case (mode)
            MODE_INSERT: begin
              if (full) begin
                res_st_d = ST_FULL;
              end else begin
                ctl.op  = CELL_INSERT;
                ctl.pos = (pos_w > cnt_w) ? cnt_w : pos_w;
                count_d = count_q + CNT_W'(1);
              end
            end
            MODE_MIN: begin
              if (empty) begin
                res_min_d = EMPTY_RANGE_MIN;
              end else begin
                scan_d = 1'b1;
                lo_d   = pos_w;
                hi_d   = hi_c;
              end
            end
            MODE_ERASE: begin
              if (pos_w >= cnt_w) begin
                res_st_d = ST_RANGE;
              end else begin
                ctl.op  = CELL_ERASE;
                count_d = count_q - CNT_W'(1);
              end
            end
            MODE_WRITE: begin
              if (pos_w >= cnt_w) begin
                res_st_d = ST_RANGE;
              end else begin
                ctl.op = CELL_WRITE;
              end
            end
            default: res_st_d = ST_OK;
          endcase
        end
      end
      S_SCAN: begin
        ctl.op     = CELL_SCAN;
        scan_cnt_d = scan_cnt_q + IDX_W'(1);
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {3'b000, len_w[LEN_W-1:0], res_st_q, min_out};
        end
      end
      default: ctl.op = CELL_HOLD;
    endcase
  end

  assign len_w   = CMP_W'(count_q);
  assign min_out = scan_q ? accs[CAPACITY-1] : res_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_cnt_q  <= scan_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    res_min_q  <= res_min_d;
    res_st_q   <= res_st_d;
    scan_q     <= scan_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: bench/psrm_scoreboard_pkg.sv
// Scoreboard for the positional range-min core: sequence predictor and result check.
package psrm_scoreboard_pkg;
  import psrm_pkg::*;

  typedef struct packed {
    logic [LEN_W-1:0]        length;
    status_e                 status;
    logic signed [VAL_W-1:0] minimum;
  } result_word_t;

  class sequence_scoreboard;
    logic signed [VAL_W-1:0] cells[$];
    result_word_t            awaited_q[$];
    int unsigned             mismatches;
    int unsigned             words_checked;
    int unsigned             mode_hits[4];
    int unsigned             full_hits;
    int unsigned             range_hits;
    int unsigned             empty_ranges;
    int unsigned             peak_length;

    function int unsigned length();
      return cells.size();
    endfunction

    function int unsigned pending();
      return awaited_q.size();
    endfunction

    function logic signed [VAL_W-1:0] span_minimum(int unsigned lo, int unsigned hi);
      logic signed [VAL_W-1:0] best;
      int unsigned             k;
      if (lo >= cells.size()) return EMPTY_RANGE_MIN;
      if (hi >= cells.size()) hi = cells.size() - 1;
      if (lo > hi) return EMPTY_RANGE_MIN;
      best = cells[lo];
      for (k = lo + 1; k <= hi; k++) begin
        if (cells[k] < best) best = cells[k];
      end
      return best;
    endfunction

    function void note_word(mode_e mode, logic [POS_W-1:0] pos, logic [REND_W-1:0] rend,
                            logic signed [VAL_W-1:0] value);
      result_word_t r;
      int unsigned  n;
      int unsigned  slot;
      n         = cells.size();
      r.minimum = '0;
      r.status  = ST_OK;
      mode_hits[mode]++;
      case (mode)
        MODE_INSERT: begin
          if (n >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            slot = (pos > n) ? n : pos;
            cells.insert(slot, value);
          end
        end
        MODE_MIN: begin
          if (pos >= n || (rend < n && pos > rend)) empty_ranges++;
          r.minimum = span_minimum(pos, rend);
        end
        MODE_ERASE: begin
          if (pos >= n) r.status = ST_RANGE;
          else cells.delete(pos);
        end
        default: begin
          if (pos >= n) r.status = ST_RANGE;
          else cells[pos] = value;
        end
      endcase
      if (r.status == ST_FULL) full_hits++;
      if (r.status == ST_RANGE) range_hits++;
      if (cells.size() > peak_length) peak_length = cells.size();
      r.length = LEN_W'(cells.size());
      awaited_q.push_back(r);
    endfunction

    function void check_word(logic [OUT_DATA_W-1:0] data);
      result_word_t got;
      result_word_t want;
      got = result_word_t'(data[$bits(result_word_t)-1:0]);
      words_checked++;
      if (awaited_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", data);
        return;
      end
      want = awaited_q.pop_front();
      if (got.minimum !== want.minimum || got.status !== want.status ||
          got.length !== want.length) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d: minimum exp %0d got %0d, status exp %0d got %0d, length exp %0d got %0d",
                   words_checked, want.minimum, got.minimum, want.status, got.status,
                   want.length, got.length);
      end
    endfunction
  endclass

endpackage

// File: bench/positional_sequence_range_min_core_test.sv
// Testbench top: drives the positional range-min core and checks every result word.
module positional_sequence_range_min_core_test
  import psrm_pkg::*, psrm_scoreboard_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 20000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  sequence_scoreboard sb = new();
  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;
  int unsigned        quiet_cycles = 0;

  positional_sequence_range_min_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_word(mode_e mode, logic [POS_W-1:0] pos, logic [REND_W-1:0] rend,
                           logic signed [VAL_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, value, rend, pos};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(mode, pos, rend, value);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic random_word();
    int unsigned             n;
    int unsigned             r;
    mode_e                   mode;
    logic [POS_W-1:0]        pos;
    logic [REND_W-1:0]       rend;
    logic signed [VAL_W-1:0] value;
    n = sb.length();
    r = $urandom_range(99);
    if (n == 0)
      mode = (r < 75) ? MODE_INSERT : mode_e'($urandom_range(3));
    else if (n > 40)
      mode = (r < 20) ? MODE_INSERT : (r < 45) ? MODE_MIN : (r < 80) ? MODE_ERASE : MODE_WRITE;
    else
      mode = (r < 40) ? MODE_INSERT : (r < 65) ? MODE_MIN : (r < 80) ? MODE_ERASE : MODE_WRITE;
    case ($urandom_range(9))
      0:       pos = POS_W'(CAPACITY);
      1:       pos = POS_W'((n + 3 > CAPACITY) ? CAPACITY : n + $urandom_range(3));
      2:       pos = POS_W'($urandom_range(CAPACITY));
      default: pos = (n == 0) ? '0 : POS_W'($urandom_range(n - 1));
    endcase
    rend = REND_W'($urandom);
    if (mode == MODE_MIN) begin
      case ($urandom_range(5))
        0:       rend = REND_W'(CAPACITY - 1);
        1:       rend = REND_W'($urandom);
        2:       rend = (pos > 0) ? REND_W'(pos - 1) : '0;
        default: rend = (pos + 8 > CAPACITY - 1) ? REND_W'(CAPACITY - 1) :
                                                   REND_W'(pos + $urandom_range(8));
      endcase
    end
    case ($urandom_range(7))
      0:       value = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      1:       value = EMPTY_RANGE_MIN + VAL_W'(int'($urandom_range(2)) - 1);
      2:       value = VAL_W'(int'($urandom_range(200)) - 100);
      default: value = $urandom;
    endcase
    send_word(mode, pos, rend, value);
  endtask

  initial begin : stimulus
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_INSERT;
    rst_ni        <= 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 71;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(MODE_MIN, 0, 0, 0);
    send_word(MODE_ERASE, 0, 0, 0);
    send_word(MODE_WRITE, 0, 0, 32'sd9);
    send_word(MODE_INSERT, 1024, 0, 32'sh7FFF_FFFF);
    send_word(MODE_INSERT, 0, 0, 32'sh8000_0000);
    send_word(MODE_INSERT, 1, 0, EMPTY_RANGE_MIN);
    send_word(MODE_INSERT, 3, 0, EMPTY_RANGE_MIN + 1);
    send_word(MODE_INSERT, 2, 0, -32'sd1);
    send_word(MODE_MIN, 0, 1023, 0);
    send_word(MODE_MIN, 3, 4, 0);
    send_word(MODE_MIN, 1, 1, 0);
    send_word(MODE_MIN, 4, 2, 0);
    send_word(MODE_MIN, 5, 9, 0);
    send_word(MODE_MIN, 1024, 1023, 0);
    send_word(MODE_WRITE, 0, 0, 32'sd5);
    send_word(MODE_MIN, 0, 1, 0);
    send_word(MODE_WRITE, 5, 0, 32'sd1);
    send_word(MODE_ERASE, 1024, 0, 0);
    send_word(MODE_ERASE, 4, 0, 0);
    send_word(MODE_ERASE, 0, 0, 0);
    send_word(MODE_MIN, 0, 1023, 0);
    send_word(MODE_ERASE, 1, 0, 0);

    repeat (210) random_word();
    drain();
    send_idle_pct = 71;
    recv_idle_pct = 8;
    repeat (210) random_word();
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (210) random_word();
    drain();
    repeat (CAPACITY + 16) @(posedge clk_i);

    $display("covered %0d inserts, %0d range minimums (%0d empty), %0d erases, %0d writes",
             sb.mode_hits[MODE_INSERT], sb.mode_hits[MODE_MIN], sb.empty_ranges,
             sb.mode_hits[MODE_ERASE], sb.mode_hits[MODE_WRITE]);
    $display("%0d full-store and %0d out-of-range rejections, peak length %0d, %0d mismatches",
             sb.full_hits, sb.range_hits, sb.peak_length, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (sb.pending() != 0) $display("%0d results never arrived", sb.pending());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: positional_sequence_range_min_core.f
rtl/core/psrm_pkg.sv
rtl/core/psrm_cell.sv
rtl/core/positional_sequence_range_min_core.sv
bench/psrm_scoreboard_pkg.sv
bench/positional_sequence_range_min_core_test.sv
